@@ rtl/ptt_pkg.sv @@
// Shared constants, action codes and cell command types for the timer bank.
package ptt_pkg;

	localparam int NUM_PERIODIC = 8;
	localparam int NUM_TIMEOUTS = 8;
	localparam int COUNT_WIDTH  = 16;

	localparam int ACTION_W = 3;
	localparam int SLOT_W   = 3;
	localparam int VALUE_W  = 16;

	localparam logic [ACTION_W-1:0] ACT_TICK      = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_START_PER = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_STOP_PER  = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_CHECK_PER = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_LOAD_TO   = 3'd4;
	localparam logic [ACTION_W-1:0] ACT_CHECK_TO  = 3'd5;

	typedef logic [COUNT_WIDTH-1:0] count_t;

	typedef struct packed {
		logic   tick;
		logic   start;
		logic   stop;
		logic   check;
		count_t value;
	} per_cmd_t;

	typedef struct packed {
		logic   tick;
		logic   load;
		logic   check;
		count_t value;
	} to_cmd_t;

endpackage

@@ rtl/ptt_period_cell.sv @@
// One periodic timer cell: counter, reload value, active and fired marks.
module ptt_period_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  ptt_pkg::per_cmd_t cmd,
	input  logic              sel,
	input  logic              ans_in,
	output logic              ans_out
);
	import ptt_pkg::*;

	count_t cnt_q;
	count_t reload_q;
	logic   active_q;
	logic   fired_q;
	count_t cnt_dec;

	assign cnt_dec = cnt_q - count_t'(1);

	// pass the answer down the row, adding this cell's fired mark when addressed by a check
	assign ans_out = ans_in | (sel & cmd.check & fired_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			reload_q <= '0;
			active_q <= 1'b0;
			fired_q  <= 1'b0;
		end else begin
			if (cmd.tick && active_q) begin
				if (cnt_dec == '0) begin
					fired_q <= 1'b1;
					cnt_q   <= reload_q;
				end else begin
					cnt_q <= cnt_dec;
				end
			end
			if (sel && cmd.start) begin
				active_q <= 1'b1;
				fired_q  <= 1'b0;
				reload_q <= cmd.value;
				cnt_q    <= cmd.value;
			end
			if (sel && cmd.stop) begin
				active_q <= 1'b0;
			end
			if (sel && cmd.check) begin
				fired_q <= 1'b0;
			end
		end
	end

endmodule

@@ rtl/ptt_timeout_cell.sv @@
// One timeout cell: a counter that runs down to zero and stays there.
module ptt_timeout_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  ptt_pkg::to_cmd_t cmd,
	input  logic             sel,
	input  logic             ans_in,
	output logic             ans_out
);
	import ptt_pkg::*;

	count_t cnt_q;
	logic   expired;

	assign expired = (cnt_q == '0);
	assign ans_out = ans_in | (sel & cmd.check & expired);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			if (sel && cmd.load) begin
				cnt_q <= cmd.value;
			end else if (cmd.tick && !expired) begin
				cnt_q <= cnt_q - count_t'(1);
			end
		end
	end

endmodule

@@ rtl/periodic_and_timeout_timer_bank.sv @@
// An accepted item's answer is registered and shows on the output in the cycle after it is accepted.
// Throughput: one item per cycle; the input stalls only while a finished
// answer sits in the output register and the output side stalls.
// All timer cells update together from one broadcast command, and the answer
// ripples through the row of cells into the output register.
// Reset: arst_n clears every counter, reload value and mark, and the output.
module periodic_and_timeout_timer_bank (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [ptt_pkg::ACTION_W-1:0]   action,
	input  logic [ptt_pkg::SLOT_W-1:0]     slot,
	input  logic [ptt_pkg::VALUE_W-1:0]    count_value,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           answer
);
	import ptt_pkg::*;

	logic     accept;
	count_t   value;
	per_cmd_t per_cmd;
	to_cmd_t  to_cmd;
	logic [NUM_PERIODIC-1:0] per_sel;
	logic [NUM_TIMEOUTS-1:0] to_sel;
	logic [NUM_PERIODIC:0]   per_ans;
	logic [NUM_TIMEOUTS:0]   to_ans;
	logic out_valid_q;
	logic answer_q;

	assign in_stall = out_valid_q & out_stall;
	assign accept   = in_valid & ~in_stall;
	assign value    = COUNT_WIDTH'(count_value);

	always_comb begin
		per_cmd       = '0;
		to_cmd        = '0;
		per_cmd.value = value;
		to_cmd.value  = value;
		unique case (action)
			ACT_TICK: begin
				per_cmd.tick = accept;
				to_cmd.tick  = accept;
			end
			ACT_START_PER: per_cmd.start = accept;
			ACT_STOP_PER:  per_cmd.stop  = accept;
			ACT_CHECK_PER: per_cmd.check = accept;
			ACT_LOAD_TO:   to_cmd.load   = accept;
			ACT_CHECK_TO:  to_cmd.check  = accept;
			default: begin
			end
		endcase
	end

	assign per_ans[0] = 1'b0;
	assign to_ans[0]  = 1'b0;

	for (genvar i = 0; i < NUM_PERIODIC; i++) begin : g_per
		assign per_sel[i] = (32'(slot) == i);
		ptt_period_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cmd     (per_cmd),
			.sel     (per_sel[i]),
			.ans_in  (per_ans[i]),
			.ans_out (per_ans[i+1])
		);
	end

	for (genvar i = 0; i < NUM_TIMEOUTS; i++) begin : g_to
		assign to_sel[i] = (32'(slot) == i);
		ptt_timeout_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cmd     (to_cmd),
			.sel     (to_sel[i]),
			.ans_in  (to_ans[i]),
			.ans_out (to_ans[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			answer_q    <= 1'b0;
		end else begin
			if (accept) begin
				out_valid_q <= 1'b1;
				answer_q    <= per_ans[NUM_PERIODIC] | to_ans[NUM_TIMEOUTS];
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign answer    = answer_q;

endmodule

@@ rtl/ptt_checker.sv @@
// Port-level checks for the timer bank, bound to the top level.
module ptt_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_stall,
	input logic [ptt_pkg::ACTION_W-1:0] action,
	input logic [ptt_pkg::SLOT_W-1:0]   slot,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic                         answer
);
	import ptt_pkg::*;

	logic in_acc;
	logic no_answer_act;

	assign in_acc = in_valid & ~in_stall;
	assign no_answer_act = (action == ACT_TICK) || (action == ACT_START_PER)
		|| (action == ACT_STOP_PER) || (action == ACT_LOAD_TO);

	// every accepted item produces an output item on the next cycle
	a_acc_gives_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> out_valid)
		else $error("accepted item produced no output");

	// actions that only change state answer zero
	a_quiet_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && no_answer_act) |=> !answer)
		else $error("non-check action answered one");

	// a check right after a start of the same slot sees the fired mark cleared
	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && action == ACT_CHECK_PER && $past(in_acc)
			&& $past(action) == ACT_START_PER && $past(slot) == slot) |=> !answer)
		else $error("fired mark survived a start");

	// hold a stalled output item
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(answer)))
		else $error("stalled output item changed");

endmodule

bind periodic_and_timeout_timer_bank ptt_checker u_ptt_checker (.*);

@@ tb/tb_periodic_and_timeout_timer_bank.sv @@
// Self-checking testbench for the periodic and timeout timer bank.
module tb_periodic_and_timeout_timer_bank;
	import ptt_pkg::*;

	localparam logic [ACTION_W-1:0] ACT_SPARE_6 = 3'd6;
	localparam logic [ACTION_W-1:0] ACT_SPARE_7 = 3'd7;

	localparam int RANDOM_ITEMS = 800;
	localparam int SOAK_TICKS   = 64;
	localparam int SOAK_CHECK   = 16;
	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = 8;
	localparam int DIRECTED_N   = 26;

	typedef enum int {STALL_NONE, STALL_SPARSE, STALL_TOGGLE, STALL_HEAVY} stall_mode_t;

	typedef struct {
		logic [ACTION_W-1:0] act;
		logic [SLOT_W-1:0]   sl;
		logic [VALUE_W-1:0]  val;
		bit                  typed;
		bit                  ans;
	} timer_row_t;

	logic                clk         = 1'b0;
	logic                arst_n      = 1'b0;
	logic                in_valid    = 1'b0;
	logic                in_stall;
	logic [ACTION_W-1:0] action      = ACT_TICK;
	logic [SLOT_W-1:0]   slot        = '0;
	logic [VALUE_W-1:0]  count_value = '0;
	logic                out_valid;
	logic                out_stall   = 1'b0;
	logic                answer;

	// typed expectation that travels with the item on the input
	bit item_has_typed    = 1'b0;
	bit item_typed_answer = 1'b0;

	// timer bank as the predictor sees it
	bit [COUNT_WIDTH-1:0] per_reload [NUM_PERIODIC];
	bit [COUNT_WIDTH-1:0] per_count  [NUM_PERIODIC];
	bit                   per_active [NUM_PERIODIC];
	bit                   per_fired  [NUM_PERIODIC];
	bit [COUNT_WIDTH-1:0] to_count   [NUM_TIMEOUTS];

	bit pending_answers [$];

	int mismatch_count  = 0;
	int items_accepted  = 0;
	int answers_checked = 0;
	int answers_set     = 0;
	int idle_cycles     = 0;
	int burst_left      = 0;

	stall_mode_t stall_mode      = STALL_NONE;
	int          stall_mode_left = 0;

	timer_row_t directed_rows [DIRECTED_N] = '{
		'{ACT_CHECK_PER, 3'd0, 16'h0000, 1'b1, 1'b0},
		'{ACT_CHECK_TO,  3'd7, 16'h0000, 1'b1, 1'b1},
		'{ACT_TICK,      3'd0, 16'h0000, 1'b1, 1'b0},
		'{ACT_START_PER, 3'd0, 16'h0000, 1'b1, 1'b0},
		'{ACT_START_PER, 3'd1, 16'h0001, 1'b1, 1'b0},
		'{ACT_START_PER, 3'd7, 16'hFFFF, 1'b1, 1'b0},
		'{ACT_LOAD_TO,   3'd0, 16'hFFFF, 1'b1, 1'b0},
		'{ACT_LOAD_TO,   3'd3, 16'h0001, 1'b1, 1'b0},
		'{ACT_TICK,      3'd7, 16'hFFFF, 1'b1, 1'b0},
		'{ACT_CHECK_PER, 3'd1, 16'h0000, 1'b1, 1'b1},
		'{ACT_CHECK_PER, 3'd1, 16'h0000, 1'b1, 1'b0},
		'{ACT_CHECK_TO,  3'd3, 16'h0000, 1'b1, 1'b1},
		'{ACT_CHECK_TO,  3'd0, 16'h0000, 1'b1, 1'b0},
		'{ACT_CHECK_PER, 3'd0, 16'h0000, 1'b0, 1'b0},
		'{ACT_STOP_PER,  3'd1, 16'h0000, 1'b1, 1'b0},
		'{ACT_TICK,      3'd2, 16'h5555, 1'b1, 1'b0},
		'{ACT_CHECK_PER, 3'd1, 16'h0000, 1'b0, 1'b0},
		'{ACT_START_PER, 3'd2, 16'h0002, 1'b1, 1'b0},
		'{ACT_TICK,      3'd0, 16'h0000, 1'b1, 1'b0},
		'{ACT_TICK,      3'd0, 16'h0000, 1'b1, 1'b0},
		'{ACT_START_PER, 3'd2, 16'h0003, 1'b1, 1'b0},
		'{ACT_CHECK_PER, 3'd2, 16'h0000, 1'b0, 1'b0},
		'{ACT_SPARE_6,   3'd5, 16'hFFFF, 1'b1, 1'b0},
		'{ACT_SPARE_7,   3'd2, 16'hAAAA, 1'b1, 1'b0},
		'{ACT_LOAD_TO,   3'd7, 16'h0000, 1'b1, 1'b0},
		'{ACT_CHECK_TO,  3'd7, 16'h0000, 1'b1, 1'b1}
	};

	periodic_and_timeout_timer_bank dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.action      (action),
		.slot        (slot),
		.count_value (count_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.answer      (answer)
	);

	always #1 clk = ~clk;

	// Advance the predicted bank by one item and return its answer.
	function automatic bit apply_timer_item(input logic [ACTION_W-1:0] act,
			input logic [SLOT_W-1:0] sl, input logic [VALUE_W-1:0] val);
		bit [COUNT_WIDTH-1:0] v;
		bit [COUNT_WIDTH-1:0] c;
		bit                   ans;
		int                   idx;
		v   = val[COUNT_WIDTH-1:0];
		ans = 1'b0;
		idx = int'(sl);
		case (act)
			ACT_TICK: begin
				for (int i = 0; i < NUM_PERIODIC; i++) begin
					if (per_active[i]) begin
						c = per_count[i] - 1'b1;
						if (c == '0) begin
							per_fired[i] = 1'b1;
							c = per_reload[i];
						end
						per_count[i] = c;
					end
				end
				for (int i = 0; i < NUM_TIMEOUTS; i++) begin
					if (to_count[i] != '0)
						to_count[i] = to_count[i] - 1'b1;
				end
			end
			ACT_START_PER: begin
				if (idx < NUM_PERIODIC) begin
					per_active[idx] = 1'b1;
					per_fired[idx]  = 1'b0;
					per_reload[idx] = v;
					per_count[idx]  = v;
				end
			end
			ACT_STOP_PER: begin
				if (idx < NUM_PERIODIC)
					per_active[idx] = 1'b0;
			end
			ACT_CHECK_PER: begin
				if (idx < NUM_PERIODIC) begin
					ans = per_fired[idx];
					per_fired[idx] = 1'b0;
				end
			end
			ACT_LOAD_TO: begin
				if (idx < NUM_TIMEOUTS)
					to_count[idx] = v;
			end
			ACT_CHECK_TO: begin
				if (idx < NUM_TIMEOUTS)
					ans = (to_count[idx] == '0);
			end
			default: ;
		endcase
		return ans;
	endfunction

	task automatic report_mismatch(input string what);
		$display("MISMATCH at %0t: %s", $time, what);
		mismatch_count++;
	endtask

	// Hold one item on the input until accepted, then maybe open a gap.
	task automatic send_item(input logic [ACTION_W-1:0] act, input logic [SLOT_W-1:0] sl,
			input logic [VALUE_W-1:0] val, input bit has_typed, input bit typed_ans);
		int gap;
		in_valid          <= 1'b1;
		action            <= act;
		slot              <= sl;
		count_value       <= val;
		item_has_typed    <= has_typed;
		item_typed_answer <= typed_ans;
		do @(posedge clk); while (!(in_valid && !in_stall));
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 6);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 24);
		end
	endtask

	// Drop valid and wait for every pending answer.
	task automatic drain_answers();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_answers.size() != 0);
	endtask

	// Check answers first, then predict for the item taken at this edge.
	always @(posedge clk) begin
		bit predicted;
		bit wanted;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_answers.size() == 0) begin
					report_mismatch($sformatf("answer %b with nothing pending", answer));
				end else begin
					wanted = pending_answers.pop_front();
					answers_checked++;
					if (wanted)
						answers_set++;
					if (answer !== wanted)
						report_mismatch($sformatf("answer %b, expected %b", answer, wanted));
				end
			end
			if (in_valid && !in_stall) begin
				predicted = apply_timer_item(action, slot, count_value);
				pending_answers.push_back(item_has_typed ? item_typed_answer : predicted);
				items_accepted++;
			end
		end
	end

	// Output stall pattern: switch between a few modes of random length.
	always @(posedge clk) begin
		if (stall_mode_left == 0) begin
			stall_mode      <= stall_mode_t'($urandom_range(0, 3));
			stall_mode_left <= $urandom_range(16, 160);
		end else begin
			stall_mode_left <= stall_mode_left - 1;
		end
		case (stall_mode)
			STALL_NONE:   out_stall <= 1'b0;
			STALL_SPARSE: out_stall <= ($urandom_range(0, 3) == 0);
			STALL_TOGGLE: out_stall <= ~out_stall;
			default:      out_stall <= (stall_mode_left[3:0] < 4'd11);
		endcase
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: nothing moved for %0d cycles, %0d answers pending",
				IDLE_LIMIT, pending_answers.size());
			$display("simulation failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		logic [ACTION_W-1:0] act;
		logic [SLOT_W-1:0]   sl;
		logic [VALUE_W-1:0]  val;
		int                  pick;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		for (int r = 0; r < DIRECTED_N; r++)
			send_item(directed_rows[r].act, directed_rows[r].sl, directed_rows[r].val,
				directed_rows[r].typed, directed_rows[r].ans);
		drain_answers();

		// zero period on slot 5 wraps to all ones and keeps counting down
		send_item(ACT_START_PER, 3'd5, '0, 1'b1, 1'b0);
		send_item(ACT_LOAD_TO, 3'd4, '1, 1'b1, 1'b0);
		for (int t = 1; t <= SOAK_TICKS; t++) begin
			send_item(ACT_TICK, t[SLOT_W-1:0], t[VALUE_W-1:0], 1'b1, 1'b0);
			if (t % SOAK_CHECK == 0) begin
				send_item(ACT_CHECK_PER, 3'd5, '0, 1'b0, 1'b0);
				send_item(ACT_CHECK_PER, 3'd0, '0, 1'b0, 1'b0);
				send_item(ACT_CHECK_TO, 3'd4, '0, 1'b0, 1'b0);
			end
		end
		drain_answers();

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS / 2 || $urandom_range(0, 199) == 0)
				drain_answers();
			pick = $urandom_range(0, 99);
			if (pick < 38)
				act = ACT_TICK;
			else if (pick < 50)
				act = ACT_START_PER;
			else if (pick < 56)
				act = ACT_STOP_PER;
			else if (pick < 72)
				act = ACT_CHECK_PER;
			else if (pick < 82)
				act = ACT_LOAD_TO;
			else if (pick < 95)
				act = ACT_CHECK_TO;
			else if (pick < 97)
				act = ACT_SPARE_6;
			else
				act = ACT_SPARE_7;
			sl   = SLOT_W'($urandom_range(0, 7));
			pick = $urandom_range(0, 9);
			// mostly short counts so timers actually run out
			if (pick < 6)
				val = VALUE_W'($urandom_range(0, 12));
			else if (pick < 8)
				val = VALUE_W'($urandom);
			else if (pick < 9)
				val = '0;
			else
				val = '1;
			send_item(act, sl, val, 1'b0, 1'b0);
		end

		drain_answers();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run covered %0d items: directed table, %0d-tick soak, %0d random items",
			items_accepted, SOAK_TICKS, RANDOM_ITEMS);
		$display("%0d answers checked, %0d of them set, %0d mismatches",
			answers_checked, answers_set, mismatch_count);
		if (mismatch_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

@@ files.f @@
rtl/ptt_pkg.sv
rtl/ptt_period_cell.sv
rtl/ptt_timeout_cell.sv
rtl/periodic_and_timeout_timer_bank.sv
rtl/ptt_checker.sv
tb/tb_periodic_and_timeout_timer_bank.sv
